>>> hw/rtl/cpios_pkg.sv
// Shared constants and register index codes for the current peak idle off switch.
package cpios_pkg;

  // Default sample width and fixed counter width
  localparam int unsigned SAMPLE_BITS_DEFAULT = 10;
  localparam int unsigned COUNT_W             = 16;

  // Configuration port layout
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam int unsigned BASELINE_RESET = 539;
  localparam int unsigned DELAY_RESET    = 0;
  localparam int unsigned THRESH_RESET   = 0;
  localparam int unsigned RATE_RESET     = 100;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_BASELINE = 3'd0,
    IDX_CLAMP    = 3'd1,
    IDX_THRESH   = 3'd2,
    IDX_DELAY    = 3'd3,
    IDX_RATE     = 3'd4
  } cfg_idx_e;

endpackage

>>> hw/rtl/cpios_cfg_regs.sv
// Configuration register file for the current peak idle off switch.
module cpios_cfg_regs #(
  parameter int unsigned SAMPLE_BITS = cpios_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [cpios_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [cpios_pkg::CFG_DATA_W-1:0] wr_data_i,
  output logic [SAMPLE_BITS-1:0]           baseline_o,
  output logic [SAMPLE_BITS-1:0]           clamp_o,
  output logic [SAMPLE_BITS-1:0]           threshold_o,
  output logic [cpios_pkg::COUNT_W-1:0]    delay_o,
  output logic [cpios_pkg::COUNT_W-1:0]    rate_o
);

  localparam logic [SAMPLE_BITS-1:0] BaseRst =
    SAMPLE_BITS'(cpios_pkg::BASELINE_RESET);
  localparam logic [SAMPLE_BITS-1:0] ThreshRst =
    SAMPLE_BITS'(cpios_pkg::THRESH_RESET);
  localparam logic [cpios_pkg::COUNT_W-1:0] DelayRst =
    cpios_pkg::COUNT_W'(cpios_pkg::DELAY_RESET);
  localparam logic [cpios_pkg::COUNT_W-1:0] RateRst =
    cpios_pkg::COUNT_W'(cpios_pkg::RATE_RESET);

  logic [SAMPLE_BITS-1:0]        baseline_q, clamp_q, threshold_q;
  logic [cpios_pkg::COUNT_W-1:0] delay_q, rate_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q  <= BaseRst;
      clamp_q     <= '1;
      threshold_q <= ThreshRst;
      delay_q     <= DelayRst;
      rate_q      <= RateRst;
    end else if (wr_en_i) begin
      case (wr_index_i)
        cpios_pkg::IDX_BASELINE: baseline_q  <= wr_data_i[SAMPLE_BITS-1:0];
        cpios_pkg::IDX_CLAMP:    clamp_q     <= wr_data_i[SAMPLE_BITS-1:0];
        cpios_pkg::IDX_THRESH:   threshold_q <= wr_data_i[SAMPLE_BITS-1:0];
        cpios_pkg::IDX_DELAY:    delay_q     <= wr_data_i[cpios_pkg::COUNT_W-1:0];
        cpios_pkg::IDX_RATE:     rate_q      <= wr_data_i[cpios_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign baseline_o  = baseline_q;
  assign clamp_o     = clamp_q;
  assign threshold_o = threshold_q;
  assign delay_o     = delay_q;
  assign rate_o      = rate_q;

endmodule

>>> hw/rtl/cpios_update.sv
// Peak tracker, idle counters and switch state, updated once per item.
module cpios_update #(
  parameter int unsigned SAMPLE_BITS = cpios_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  input  logic [SAMPLE_BITS-1:0]        baseline_i,
  input  logic [SAMPLE_BITS-1:0]        clamp_i,
  input  logic [SAMPLE_BITS-1:0]        threshold_i,
  input  logic [cpios_pkg::COUNT_W-1:0] delay_i,
  input  logic [cpios_pkg::COUNT_W-1:0] rate_i,
  output logic                          on_d_o,
  output logic [SAMPLE_BITS-1:0]        peak_d_o,
  output logic [cpios_pkg::COUNT_W-1:0] sec_d_o
);

  localparam int unsigned CW = cpios_pkg::COUNT_W;

  logic [SAMPLE_BITS-1:0] peak_q, peak_d;
  logic [CW-1:0]          tick_q, tick_d;
  logic [CW-1:0]          sec_q, sec_d;
  logic                   on_q, on_d;

  logic [SAMPLE_BITS-1:0] mag, mag_clamped;
  logic [CW-1:0]          rate_eff;
  logic [CW:0]            tick_inc;
  logic [CW-1:0]          sec_inc;

  // Magnitude around the baseline, then clamp
  always_comb begin
    mag         = (sample_i >= baseline_i) ? sample_i - baseline_i
                                           : baseline_i - sample_i;
    mag_clamped = (mag > clamp_i) ? clamp_i : mag;
    rate_eff    = (rate_i == '0) ? CW'(1) : rate_i;
  end

  // Peak, idle counting and switch decision
  always_comb begin
    peak_d   = peak_q;
    tick_d   = tick_q;
    sec_d    = sec_q;
    on_d     = on_q;
    tick_inc = {1'b0, tick_q} + (CW+1)'(1);
    sec_inc  = sec_q;

    if (mag_clamped > peak_q) begin
      peak_d = mag_clamped;
    end else if (peak_q != '0) begin
      peak_d = peak_q - SAMPLE_BITS'(1);
    end

    if (peak_d <= threshold_i) begin
      if (sec_q < delay_i) begin
        if (tick_inc >= {1'b0, rate_eff}) begin
          tick_d  = '0;
          sec_inc = sec_q + CW'(1);
        end else begin
          tick_d = tick_inc[CW-1:0];
        end
        sec_d = sec_inc;
        if (sec_inc >= delay_i) begin
          on_d = 1'b0;
        end
      end
    end else if (!on_q) begin
      on_d   = 1'b1;
      tick_d = '0;
      sec_d  = '0;
    end
  end

  // State registers advance when an item passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
      tick_q <= '0;
      sec_q  <= '0;
      on_q   <= 1'b1;
    end else if (step_i) begin
      peak_q <= peak_d;
      tick_q <= tick_d;
      sec_q  <= sec_d;
      on_q   <= on_d;
    end
  end

  assign on_d_o   = on_d;
  assign peak_d_o = peak_d;
  assign sec_d_o  = sec_d;

endmodule

>>> hw/rtl/current_peak_idle_off_switch_core.sv
// Top level of the current peak idle off switch: handshake stages and wiring.
//
// Usage: one converter sample enters per item on the input channel
// (in_valid_i / in_stall_o / raw_sample_i). Each item gives exactly one result
// on the output channel (out_valid_o / out_stall_i) carrying the switch state,
// the decaying peak and the idle seconds after that sample.
// Items pass an input register, then the update logic writes the result
// register, which drives the output channel.
// Throughput is one item per cycle while the receiver does not stall; the
// update between the input and result registers is combinational.
// When the receiver stalls, the result register holds and the input register
// keeps one more item; further items are stalled until the result is taken.
// Registers are written through cfg_valid_i / cfg_ready_o with an index and
// data; ready is always high, and writes belong to times when no item is in
// flight.
// Reset (rst_ni low, asynchronous) empties both stages, loads the register
// defaults and sets peak and counters to zero with the output on.
module current_peak_idle_off_switch_core #(
  parameter int unsigned SAMPLE_BITS = cpios_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [SAMPLE_BITS-1:0]           raw_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             output_on_o,
  output logic [SAMPLE_BITS-1:0]           peak_level_o,
  output logic [cpios_pkg::COUNT_W-1:0]    idle_seconds_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cpios_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cpios_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [SAMPLE_BITS-1:0]        baseline, clamp, threshold;
  logic [cpios_pkg::COUNT_W-1:0] delay, rate;

  logic                          s1_valid_q;
  logic [SAMPLE_BITS-1:0]        s1_sample_q;
  logic                          out_valid_q;
  logic                          out_on_q;
  logic [SAMPLE_BITS-1:0]        out_peak_q;
  logic [cpios_pkg::COUNT_W-1:0] out_sec_q;

  logic                          s1_advance, in_accept;
  logic                          on_d;
  logic [SAMPLE_BITS-1:0]        peak_d;
  logic [cpios_pkg::COUNT_W-1:0] sec_d;

  assign cfg_ready_o = 1'b1;

  cpios_cfg_regs #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .baseline_o (baseline),
    .clamp_o    (clamp),
    .threshold_o(threshold),
    .delay_o    (delay),
    .rate_o     (rate)
  );

  // Handshake: stage 1 moves on when the result register is free or drains
  assign s1_advance = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_advance;
  assign in_accept  = in_valid_i & ~in_stall_o;

  cpios_update #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (s1_advance),
    .sample_i   (s1_sample_q),
    .baseline_i (baseline),
    .clamp_i    (clamp),
    .threshold_i(threshold),
    .delay_i    (delay),
    .rate_i     (rate),
    .on_d_o     (on_d),
    .peak_d_o   (peak_d),
    .sec_d_o    (sec_d)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_q <= raw_sample_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_on_q   <= on_d;
      out_peak_q <= peak_d;
      out_sec_q  <= sec_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign output_on_o    = out_on_q;
  assign peak_level_o   = out_peak_q;
  assign idle_seconds_o = out_sec_q;

endmodule

>>> hw/rtl/cpios_checker.sv
// Port-level checks for the current peak idle off switch, bound to the top level.
module cpios_checker #(
  parameter int unsigned SAMPLE_BITS = cpios_pkg::SAMPLE_BITS_DEFAULT
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic                             output_on_o,
  input logic [SAMPLE_BITS-1:0]           peak_level_o,
  input logic [cpios_pkg::COUNT_W-1:0]    idle_seconds_o
);

  logic out_take;
  assign out_take = out_valid_o & ~out_stall_i;

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(peak_level_o)
      && $stable(idle_seconds_o) && $stable(output_on_o))
  else $error("stalled result changed");

  // Input only backs up behind a stalled full result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
  else $error("input stalled while output side free");

  // Peak decays by at most one per item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take ##1 out_take |-> peak_level_o >= $past(peak_level_o)
      || peak_level_o == $past(peak_level_o) - SAMPLE_BITS'(1))
  else $error("peak fell by more than one step");

  // Idle seconds advance by one, hold, or clear between items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take ##1 out_take |-> idle_seconds_o == $past(idle_seconds_o)
      || idle_seconds_o == $past(idle_seconds_o) + cpios_pkg::COUNT_W'(1)
      || idle_seconds_o == '0)
  else $error("idle seconds jumped");

endmodule

bind current_peak_idle_off_switch_core cpios_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_cpios_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .output_on_o   (output_on_o),
  .peak_level_o  (peak_level_o),
  .idle_seconds_o(idle_seconds_o)
);

>>> tb/sv/testbench.sv
// Testbench for current_peak_idle_off_switch_core: directed and random checks against a predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned SAMPLE_W   = cpios_pkg::SAMPLE_BITS_DEFAULT;
  localparam int unsigned COUNT_W    = cpios_pkg::COUNT_W;
  localparam int unsigned CFG_IDX_W  = cpios_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = cpios_pkg::CFG_DATA_W;
  localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int unsigned COUNT_MAX  = (1 << COUNT_W) - 1;

  // Indexes past the last register; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_MID = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI  = 3'd7;

  // One output item: switch state, held peak, idle seconds
  typedef struct packed {
    logic               switched_on;
    logic [SAMPLE_W-1:0] peak;
    logic [COUNT_W-1:0]  seconds;
  } readout_t;

  logic                  clk;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [SAMPLE_W-1:0]   raw_sample_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  output_on_o;
  logic [SAMPLE_W-1:0]   peak_level_o;
  logic [COUNT_W-1:0]    idle_seconds_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  current_peak_idle_off_switch_core #(
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .raw_sample_i  (raw_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .output_on_o   (output_on_o),
    .peak_level_o  (peak_level_o),
    .idle_seconds_o(idle_seconds_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predictor copy of the registers and state
  int unsigned cfg_baseline = cpios_pkg::BASELINE_RESET;
  int unsigned cfg_clamp    = SAMPLE_MAX;
  int unsigned cfg_thresh   = cpios_pkg::THRESH_RESET;
  int unsigned cfg_delay    = cpios_pkg::DELAY_RESET;
  int unsigned cfg_rate     = cpios_pkg::RATE_RESET;
  int unsigned held_peak    = 0;
  int unsigned idle_ticks   = 0;
  int unsigned idle_secs    = 0;
  bit          switch_on    = 1'b1;

  readout_t    expected_readouts[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("current_peak_idle_off_switch_core test failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Peak tracking and idle timing for one accepted sample
  task automatic track_peak_and_idle(input logic [SAMPLE_W-1:0] raw);
    int unsigned mag;
    int unsigned per_second;
    readout_t    r;
    mag = (raw >= cfg_baseline) ? raw - cfg_baseline : cfg_baseline - raw;
    if (mag > cfg_clamp) mag = cfg_clamp;
    per_second = (cfg_rate == 0) ? 1 : cfg_rate;
    if (mag > held_peak) held_peak = mag;
    else if (held_peak > 0) held_peak--;
    if (held_peak <= cfg_thresh) begin
      if (idle_secs < cfg_delay) begin
        idle_ticks++;
        if (idle_ticks >= per_second) begin
          idle_ticks = 0;
          idle_secs++;
        end
        if (idle_secs >= cfg_delay) switch_on = 1'b0;
      end
    end else if (!switch_on) begin
      switch_on  = 1'b1;
      idle_ticks = 0;
      idle_secs  = 0;
    end
    r.switched_on = switch_on;
    r.peak        = held_peak[SAMPLE_W-1:0];
    r.seconds     = idle_secs[COUNT_W-1:0];
    expected_readouts.push_back(r);
  endtask

  // Register write; the port is released afterwards
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk);
      taken = cfg_ready_o;
      @(posedge clk);
    end while (!taken);
    case (idx)
      cpios_pkg::IDX_BASELINE: cfg_baseline = data & SAMPLE_MAX;
      cpios_pkg::IDX_CLAMP:    cfg_clamp    = data & SAMPLE_MAX;
      cpios_pkg::IDX_THRESH:   cfg_thresh   = data & SAMPLE_MAX;
      cpios_pkg::IDX_DELAY:    cfg_delay    = data & COUNT_MAX;
      cpios_pkg::IDX_RATE:     cfg_rate     = data & COUNT_MAX;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk);
  endtask

  // Send one sample; bursts of random length with random gaps between them
  task automatic send_sample(input logic [SAMPLE_W-1:0] raw);
    int unsigned gap;
    bit          taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    raw_sample_i <= raw;
    do begin
      @(negedge clk);
      taken = !in_stall_o;
      @(posedge clk);
    end while (!taken);
    track_peak_and_idle(raw);
  endtask

  // Stop sending and wait until every expected result is out
  task automatic wait_until_settled();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_readouts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver stall pattern: modes of random length
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned run_left;
    bit          hold;
    out_stall_i = 1'b0;
    mode_left = 0;
    run_left  = 0;
    hold      = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      case (mode)
        0: hold = 1'b0;
        1: hold = ($urandom_range(0, 3) == 0);
        2: hold = ($urandom_range(0, 9) < 7);
        default: begin
          if (run_left == 0) begin
            hold     = !hold;
            run_left = $urandom_range(1, 12);
          end
          run_left--;
        end
      endcase
      out_stall_i <= hold;
    end
  end

  // Result check at the cycle before each accepting edge
  always @(negedge clk) begin
    readout_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_readouts.size() == 0) begin
        report_mismatch("result with no sample pending");
      end else begin
        want = expected_readouts.pop_front();
        if (output_on_o !== want.switched_on)
          report_mismatch($sformatf("output_on got %0b expected %0b",
                                    output_on_o, want.switched_on));
        if (peak_level_o !== want.peak)
          report_mismatch($sformatf("peak_level got %0d expected %0d",
                                    peak_level_o, want.peak));
        if (idle_seconds_o !== want.seconds)
          report_mismatch($sformatf("idle_seconds got %0d expected %0d",
                                    idle_seconds_o, want.seconds));
      end
    end
  end

  // Idle run to switch-off, then switch back on and a spike while on
  task automatic test_off_delay();
    write_register(cpios_pkg::IDX_THRESH, 16'd2);
    write_register(cpios_pkg::IDX_DELAY, 16'd2);
    write_register(cpios_pkg::IDX_RATE, 16'd2);
    send_sample(10'd539);
    send_sample(10'd540);
    send_sample(10'd538);
    send_sample(10'd539);
    send_sample(10'd545);
    send_sample(10'd539);
    send_sample(10'd550);
    wait_until_settled();
  endtask

  // Lowered rate below the tick count wraps; a zero rate counts as one
  task automatic test_tick_rate();
    write_register(cpios_pkg::IDX_THRESH, CFG_DATA_W'(SAMPLE_MAX));
    write_register(cpios_pkg::IDX_RATE, 16'd4);
    write_register(cpios_pkg::IDX_DELAY, 16'd3);
    repeat (3) send_sample(10'd539);
    wait_until_settled();
    write_register(cpios_pkg::IDX_RATE, 16'd2);
    send_sample(10'd539);
    wait_until_settled();
    write_register(cpios_pkg::IDX_RATE, 16'd0);
    repeat (2) send_sample(10'd539);
    wait_until_settled();
  endtask

  // Delay lowered under the counted seconds stops counting, output stays on
  task automatic test_lowered_delay();
    write_register(cpios_pkg::IDX_THRESH, 16'd0);
    send_sample(10'd539);
    wait_until_settled();
    write_register(cpios_pkg::IDX_THRESH, CFG_DATA_W'(SAMPLE_MAX));
    write_register(cpios_pkg::IDX_DELAY, 16'd10);
    write_register(cpios_pkg::IDX_RATE, 16'd1);
    repeat (3) send_sample(10'd539);
    wait_until_settled();
    write_register(cpios_pkg::IDX_DELAY, 16'd2);
    repeat (2) send_sample(10'd539);
    wait_until_settled();
  endtask

  // Zero delay: nothing counted, never off
  task automatic test_zero_delay();
    write_register(cpios_pkg::IDX_DELAY, 16'd0);
    send_sample(10'd0);
    send_sample(10'd539);
    wait_until_settled();
  endtask

  // Baseline and clamp extremes, upper data bits masked off
  task automatic test_magnitude_clamp();
    write_register(cpios_pkg::IDX_BASELINE, 16'd0);
    write_register(cpios_pkg::IDX_CLAMP, CFG_DATA_W'(SAMPLE_MAX));
    send_sample(10'd1023);
    send_sample(10'd0);
    wait_until_settled();
    write_register(cpios_pkg::IDX_BASELINE, 16'hFFFF);
    write_register(cpios_pkg::IDX_CLAMP, 16'hFC64);
    send_sample(10'd0);
    send_sample(10'd1023);
    wait_until_settled();
    write_register(cpios_pkg::IDX_CLAMP, 16'd0);
    send_sample(10'd500);
    wait_until_settled();
  endtask

  // Writes past the last register leave everything unchanged
  task automatic test_spare_index();
    write_register(IDX_SPARE_LO, 16'hFFFF);
    write_register(IDX_SPARE_MID, 16'h0000);
    write_register(IDX_SPARE_HI, 16'h5A5A);
    send_sample(10'd777);
    wait_until_settled();
  endtask

  function automatic logic [CFG_DATA_W-1:0] with_upper_noise(input int unsigned value);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(value);
    if ($urandom_range(0, 3) == 0)
      data[CFG_DATA_W-1:SAMPLE_W] = (CFG_DATA_W-SAMPLE_W)'($urandom);
    return data;
  endfunction

  // Mostly idle readings around the baseline with spikes; some pure noise
  function automatic logic [SAMPLE_W-1:0] pick_sample(input bit noisy);
    int          level;
    int          offset;
    logic [31:0] any;
    if (noisy || $urandom_range(0, 59) == 0) begin
      any = $urandom_range(0, SAMPLE_MAX);
      return any[SAMPLE_W-1:0];
    end
    if ($urandom_range(0, 11) == 0)
      offset = int'(cfg_thresh) + int'($urandom_range(1, 20));
    else offset = int'($urandom_range(0, cfg_thresh / 2 + 1));
    level = $urandom_range(0, 1) ? int'(cfg_baseline) + offset
                                 : int'(cfg_baseline) - offset;
    if (level < 0) level = 0;
    if (level > int'(SAMPLE_MAX)) level = int'(SAMPLE_MAX);
    return level[SAMPLE_W-1:0];
  endfunction

  // Random phases, each with its own register setting
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned n;
    int unsigned r;
    int unsigned base;
    int unsigned clamp;
    int unsigned thresh;
    int unsigned delay;
    int unsigned rate;
    bit          noisy;
    for (phase = 0; phase < 16; phase++) begin
      wait_until_settled();
      r = $urandom_range(0, 5);
      base = (r == 0) ? 0 : (r == 1) ? SAMPLE_MAX : $urandom_range(300, 700);
      r = $urandom_range(0, 5);
      clamp = (r == 0) ? 0 : (r == 1) ? SAMPLE_MAX : $urandom_range(40, SAMPLE_MAX);
      r = $urandom_range(0, 5);
      thresh = (r == 0) ? 0 : (r == 1) ? SAMPLE_MAX : $urandom_range(1, 30);
      r = $urandom_range(0, 5);
      delay = (r == 0) ? 0 : (r == 1) ? COUNT_MAX : $urandom_range(1, 4);
      r = $urandom_range(0, 5);
      rate = (r == 0) ? 0 : (r == 1) ? COUNT_MAX : $urandom_range(1, 6);
      // one phase always runs the widest counters
      if (phase == 1) begin
        delay = COUNT_MAX;
        rate  = COUNT_MAX;
      end
      write_register(cpios_pkg::IDX_BASELINE, with_upper_noise(base));
      write_register(cpios_pkg::IDX_CLAMP, with_upper_noise(clamp));
      write_register(cpios_pkg::IDX_THRESH, with_upper_noise(thresh));
      write_register(cpios_pkg::IDX_DELAY, CFG_DATA_W'(delay));
      write_register(cpios_pkg::IDX_RATE, CFG_DATA_W'(rate));
      if ($urandom_range(0, 3) == 0) write_register(IDX_SPARE_MID, CFG_DATA_W'($urandom));
      noisy = ($urandom_range(0, 4) == 0);
      for (n = 0; n < 100; n++) send_sample(pick_sample(noisy));
    end
    wait_until_settled();
  endtask

  // Sequence
  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    raw_sample_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = cpios_pkg::IDX_BASELINE;
    cfg_data_i   = '0;
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_off_delay();
    test_tick_rate();
    test_lowered_delay();
    test_zero_delay();
    test_magnitude_clamp();
    test_spare_index();
    test_random_traffic();

    if (expected_readouts.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_readouts.size()));
    if (mismatch_count == 0) begin
      $display("current_peak_idle_off_switch_core test passed");
    end else begin
      $display("current_peak_idle_off_switch_core test failed");
    end
    $finish;
  end

endmodule
